// ===== src/kthc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kthc_pkg
// Shared types and constants of the k-mer table hit counter.
// ----------------------------------------------------------------------------
package kthc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int NUM_W       = IDX_W + 1;
    localparam int KMER_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int MAX_K       = 32;
    localparam int K_W         = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BASE  = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd1;

    localparam logic [K_W-1:0] KMER_LENGTH_RESET = 6'd25;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  entry_index;
        logic [KMER_W-1:0] entry_kmer;
        logic [7:0]        base_char;
        logic              read_end;
    } cmd_t;

    typedef struct packed {
        logic               kmer_ready;
        logic               hit;
        logic [IDX_W-1:0]   hit_index;
        logic [COUNT_W-1:0] count_value;
    } result_t;

    typedef struct packed {
        logic              kmer_ready;
        logic [KMER_W-1:0] key;
    } win_t;

endpackage

`default_nettype wire

// ===== src/kthc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kthc_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module kthc_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/kthc_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kthc_window
// Base window: folds case, packs bases, tracks the regular run, forms the key.
// ----------------------------------------------------------------------------
module kthc_window (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    shift_en,
    input  wire logic [7:0]              base_char,
    input  wire logic                    read_end,
    input  wire logic [kthc_pkg::K_W-1:0] k,
    output kthc_pkg::win_t               win
);
    import kthc_pkg::*;

    logic [KMER_W-1:0] window_reg;
    logic [K_W-1:0]    run_reg;
    logic [KMER_W-1:0] key_reg;
    logic              ready_reg;

    logic [7:0]        upper;
    logic [1:0]        code;
    logic              regular;
    logic [KMER_W-1:0] window_next;
    logic [K_W-1:0]    run_next;
    logic [K_W:0]      shift_amt;
    logic [KMER_W-1:0] mask;

    always_comb
    begin
        upper = base_char;
        if (base_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
        begin
            upper = base_char - CASE_OFFSET;
        end
        regular = 1'b1;
        code    = 2'd0;
        case (upper)
            CHAR_A:  code = 2'd0;
            CHAR_C:  code = 2'd1;
            CHAR_G:  code = 2'd2;
            CHAR_T:  code = 2'd3;
            default: regular = 1'b0;
        endcase
        window_next = {window_reg[KMER_W-3:0], code};
        run_next    = (run_reg < k) ? run_reg + 1'b1 : k;
        shift_amt   = (K_W + 1)'(KMER_W) - {k, 1'b0};
        mask        = {KMER_W{1'b1}} >> shift_amt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            run_reg    <= '0;
            key_reg    <= '0;
            ready_reg  <= 1'b0;
        end
        else if (shift_en)
        begin
            key_reg   <= window_next & mask;
            ready_reg <= regular && (run_next == k);
            if (!regular || read_end)
            begin
                window_reg <= '0;
                run_reg    <= '0;
            end
            else
            begin
                window_reg <= window_next;
                run_reg    <= run_next;
            end
        end
    end

    assign win.kmer_ready = ready_reg;
    assign win.key        = key_reg;

endmodule

`default_nettype wire

// ===== src/kmer_table_hit_counter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_table_hit_counter_unit
// Counts hits of read k-mers against a sorted reference table by binary search.
// ----------------------------------------------------------------------------
//  channel   signals                                 handshake
//  command   start, busy, cmd                        taken when start & !busy
//  result    done, result                            one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  taken when valid & ready
//
//  After reset a clearing pass zeroes the count memory, busy high.
//  Load and unused mode answer from idle; a count read passes through S_COUNT.
//  Base without a k-mer ends in S_PROBE; with one, each probe of the search
//  (up to 13 at 4096 entries) takes S_PROBE and S_CMP, then S_CHECK counts the hit.
//  Config is always ready, also during the clearing pass.
// ----------------------------------------------------------------------------
module kmer_table_hit_counter_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire kthc_pkg::cmd_t                 cmd,
    output logic                                done,
    output kthc_pkg::result_t                   result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kthc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kthc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kthc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_PROBE,
        S_CMP,
        S_CHECK
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic [K_W-1:0]     kmer_length_reg;
    logic [NUM_W-1:0]   entry_count_reg;
    logic [NUM_W-1:0]   lo_reg;
    logic [NUM_W-1:0]   hi_reg;
    logic [NUM_W-1:0]   mid_reg;
    logic               done_reg;
    result_t            result_reg;

    logic               accept;
    logic [K_W-1:0]     eff_k;
    logic [NUM_W-1:0]   n_eff;
    logic [NUM_W-1:0]   mid;
    logic               key_lt;
    logic               key_eq;
    logic               hit;
    logic [COUNT_W-1:0] cnt_new;
    win_t               win;

    logic               kmer_we;
    logic [IDX_W-1:0]   kmer_addr;
    logic [KMER_W-1:0]  kmer_rdata;
    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_addr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [COUNT_W-1:0] cnt_rdata;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        if (kmer_length_reg == '0)
        begin
            eff_k = K_W'(1);
        end
        else if (kmer_length_reg > K_W'(MAX_K))
        begin
            eff_k = K_W'(MAX_K);
        end
        else
        begin
            eff_k = kmer_length_reg;
        end
        n_eff = (entry_count_reg > NUM_W'(TABLE_DEPTH)) ? NUM_W'(TABLE_DEPTH)
                                                        : entry_count_reg;
        mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
        key_lt  = kmer_rdata < win.key;
        key_eq  = kmer_rdata == win.key;
        hit     = (lo_reg < n_eff) && key_eq;
        cnt_new = (cnt_rdata == {COUNT_W{1'b1}}) ? cnt_rdata : cnt_rdata + 1'b1;
    end

    // table port steering
    always_comb
    begin
        kmer_we   = 1'b0;
        kmer_addr = lo_reg[IDX_W-1:0];
        cnt_we    = 1'b0;
        cnt_addr  = lo_reg[IDX_W-1:0];
        cnt_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we   = 1'b1;
                cnt_addr = clr_addr_reg;
            end
            S_IDLE:
            begin
                kmer_addr = cmd.entry_index;
                cnt_addr  = cmd.entry_index;
                kmer_we   = accept && (cmd.mode == MODE_LOAD);
                cnt_we    = accept && (cmd.mode == MODE_LOAD);
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    kmer_addr = mid[IDX_W-1:0];
                end
            end
            S_CHECK:
            begin
                cnt_we    = hit;
                cnt_wdata = cnt_new;
            end
            default:
            begin
                kmer_we = 1'b0;
            end
        endcase
    end

    kthc_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (KMER_W)
    ) u_kmer_ram (
        .clk   (clk),
        .we    (kmer_we),
        .addr  (kmer_addr),
        .wdata (cmd.entry_kmer),
        .rdata (kmer_rdata)
    );

    kthc_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (COUNT_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    kthc_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept && (cmd.mode == MODE_BASE)),
        .base_char (cmd.base_char),
        .read_end  (cmd.read_end),
        .k         (eff_k),
        .win       (win)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            kmer_length_reg <= KMER_LENGTH_RESET;
            entry_count_reg <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            mid_reg         <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KMER_LENGTH: kmer_length_reg <= cfg_data[K_W-1:0];
                    REG_ENTRY_COUNT: entry_count_reg <= cfg_data[NUM_W-1:0];
                    default:         entry_count_reg <= entry_count_reg;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == {IDX_W{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        result_reg <= '0;
                        lo_reg     <= '0;
                        hi_reg     <= n_eff;
                        case (cmd.mode)
                            MODE_BASE:  state_reg <= S_PROBE;
                            MODE_COUNT: state_reg <= S_COUNT;
                            default:    done_reg  <= 1'b1;
                        endcase
                    end
                end
                S_COUNT:
                begin
                    result_reg.count_value <= cnt_rdata;
                    done_reg               <= 1'b1;
                    state_reg              <= S_IDLE;
                end
                S_PROBE:
                begin
                    if (!win.kmer_ready)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CMP:
                begin
                    if (key_lt)
                    begin
                        lo_reg <= mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_PROBE;
                end
                S_CHECK:
                begin
                    result_reg.kmer_ready <= 1'b1;
                    if (hit)
                    begin
                        result_reg.hit         <= 1'b1;
                        result_reg.hit_index   <= lo_reg[IDX_W-1:0];
                        result_reg.count_value <= cnt_new;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_kmer_table_hit_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmer_table_hit_counter_unit
// Loads sorted k-mer tables, streams read bases built from table k-mers mixed
// with noise, and checks every result word against a cycle-free predictor of
// the window, the binary search and the hit counts, across k-mer lengths and
// table sizes starting from empty.
// ----------------------------------------------------------------------------
module tb_kmer_table_hit_counter_unit;
    import kthc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 20000;

    class kmer_hit_tracker;
        logic [K_W-1:0]     kmer_length;
        logic [NUM_W-1:0]   entry_count;
        logic [KMER_W-1:0]  window;
        int unsigned        run_len;
        logic [KMER_W-1:0]  kmer_store [TABLE_DEPTH];
        logic [COUNT_W-1:0] hit_counts [TABLE_DEPTH];
        result_t            expected_words [$];
        int unsigned        mismatches;

        function new();
            kmer_length = KMER_LENGTH_RESET;
            entry_count = '0;
            window      = '0;
            run_len     = 0;
            mismatches  = 0;
            foreach (hit_counts[i])
            begin
                hit_counts[i] = '0;
                kmer_store[i] = '0;
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_KMER_LENGTH)
                kmer_length = data[K_W-1:0];
            else if (idx == REG_ENTRY_COUNT)
                entry_count = data[NUM_W-1:0];
        endfunction

        function void note_command(cmd_t c);
            result_t           r;
            logic [7:0]        ch;
            logic [1:0]        code;
            bit                regular;
            int unsigned       k, n, lo, hi, mid;
            logic [KMER_W-1:0] mask, key;
            r = '0;
            case (c.mode)
                MODE_LOAD:
                begin
                    kmer_store[c.entry_index] = c.entry_kmer;
                    hit_counts[c.entry_index] = '0;
                end
                MODE_COUNT:
                    r.count_value = hit_counts[c.entry_index];
                MODE_BASE:
                begin
                    k = (kmer_length == 0) ? 1 : ((kmer_length > MAX_K) ? MAX_K : kmer_length);
                    ch = c.base_char;
                    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
                        ch = ch - CASE_OFFSET;
                    regular = 1'b1;
                    code = 2'd0;
                    case (ch)
                        CHAR_A: code = 2'd0;
                        CHAR_C: code = 2'd1;
                        CHAR_G: code = 2'd2;
                        CHAR_T: code = 2'd3;
                        default: regular = 1'b0;
                    endcase
                    if (!regular)
                    begin
                        window  = '0;
                        run_len = 0;
                    end
                    else
                    begin
                        mask = (k >= MAX_K) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
                        window = {window[KMER_W-3:0], code};
                        if (run_len < k)
                            run_len++;
                        if (run_len > k)
                            run_len = k;
                        if (run_len >= k)
                        begin
                            key = window & mask;
                            n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
                            lo = 0;
                            hi = n;
                            while (lo < hi)
                            begin
                                mid = lo + ((hi - lo) >> 1);
                                if (kmer_store[mid] < key)
                                    lo = mid + 1;
                                else
                                    hi = mid;
                            end
                            r.kmer_ready = 1'b1;
                            if (lo < n && kmer_store[lo] == key)
                            begin
                                if (hit_counts[lo] != '1)
                                    hit_counts[lo]++;
                                r.hit         = 1'b1;
                                r.hit_index   = lo[IDX_W-1:0];
                                r.count_value = hit_counts[lo];
                            end
                        end
                    end
                    if (c.read_end)
                    begin
                        window  = '0;
                        run_len = 0;
                    end
                end
                default: ;
            endcase
            expected_words.push_back(r);
        endfunction

        task report(string what, logic [63:0] want, logic [63:0] seen);
            mismatches++;
            if (mismatches <= 100)
                $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, seen);
        endtask

        task match_result(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                report("word with nothing outstanding", '0, got);
                return;
            end
            want = expected_words.pop_front();
            if (got.kmer_ready !== want.kmer_ready)
                report("kmer_ready", want.kmer_ready, got.kmer_ready);
            if (got.hit !== want.hit)
                report("hit", want.hit, got.hit);
            if (got.hit_index !== want.hit_index)
                report("hit_index", want.hit_index, got.hit_index);
            if (got.count_value !== want.count_value)
                report("count_value", want.count_value, got.count_value);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    cmd_t                  cmd       = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    kmer_hit_tracker       tracker;
    bit                    idle_on;
    bit                    moved;
    int unsigned           stalled_cycles = 0;
    int unsigned           plan_len;
    logic [KMER_W-1:0]     table_keys [$];
    int unsigned           base_plan [$];
    logic [7:0]            letters [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

    kmer_table_hit_counter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                tracker.write_register(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (start && !busy)
            begin
                tracker.note_command(cmd);
                moved = 1'b1;
            end
            if (done)
            begin
                tracker.match_result(result);
                moved = 1'b1;
            end
            stalled_cycles = moved ? 0 : stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic cmd_t random_cmd();
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        return noise[$bits(cmd_t)-1:0];
    endfunction

    task automatic send_command(input cmd_t c);
        bit taken;
        taken = 1'b0;
        cmd <= c;
        while (!taken)
        begin
            if (idle_on && $urandom_range(0, 99) < 6)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                start <= 1'b1;
                @(posedge clk);
                taken = !busy;
            end
        end
    endtask

    // hold off new words until every outstanding word is back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_registers(input logic [CFG_DATA_W-1:0] length_word,
                                   input logic [CFG_DATA_W-1:0] count_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_KMER_LENGTH;
        cfg_data  <= length_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_ENTRY_COUNT;
        cfg_data  <= count_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] length_word(input int unsigned k_setting);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom);
        w[K_W-1:0] = k_setting[K_W-1:0];
        return w;
    endfunction

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic [KMER_W-1:0] kmer);
        cmd_t c;
        c = random_cmd();
        c.mode        = MODE_LOAD;
        c.entry_index = idx;
        c.entry_kmer  = kmer;
        send_command(c);
    endtask

    task automatic send_count(input logic [IDX_W-1:0] idx);
        cmd_t c;
        c = random_cmd();
        c.mode        = MODE_COUNT;
        c.entry_index = idx;
        send_command(c);
    endtask

    task automatic send_base(input logic [7:0] ch, input bit last);
        cmd_t c;
        c = random_cmd();
        c.mode      = MODE_BASE;
        c.base_char = ch;
        c.read_end  = last;
        send_command(c);
    endtask

    task automatic stream_reads(input int unsigned items);
        cmd_t              c;
        int unsigned       roll, code, i, j;
        logic [KMER_W-1:0] key;
        i = 0;
        while (i < items)
        begin
            roll = $urandom_range(0, 99);
            c = random_cmd();
            if (roll < 2)
                drain();
            else if (roll < 8)
            begin
                c.mode = MODE_COUNT;
                if (table_keys.size() != 0 && $urandom_range(0, 1) == 1)
                    c.entry_index = IDX_W'($urandom_range(0, table_keys.size() - 1));
            end
            else if (roll < 10)
                c.mode = MODE_UNUSED;
            else if (roll < 13)
            begin
                c.mode = MODE_LOAD;
                // reload a table entry with its own key: keeps order, clears count
                if (table_keys.size() != 0 && $urandom_range(0, 3) != 0)
                begin
                    c.entry_index = IDX_W'($urandom_range(0, table_keys.size() - 1));
                    c.entry_kmer  = table_keys[c.entry_index];
                end
            end
            else
            begin
                c.mode = MODE_BASE;
                if (base_plan.size() == 0)
                begin
                    if (table_keys.size() != 0 && $urandom_range(0, 99) < 60)
                    begin
                        key = table_keys[$urandom_range(0, table_keys.size() - 1)];
                        for (j = plan_len; j > 0; j--)
                            base_plan.push_back(int'((key >> (2 * (j - 1))) & 64'd3));
                    end
                    else
                        repeat ($urandom_range(1, 6))
                            base_plan.push_back($urandom_range(0, 3));
                end
                code = base_plan.pop_front();
                c.base_char = letters[code];
                if ($urandom_range(0, 99) < 8)
                    c.base_char = letters[code] + CASE_OFFSET;
                if ($urandom_range(0, 99) < 2)
                    c.base_char = 8'($urandom_range(0, 255));
                c.read_end = ($urandom_range(0, 99) < 2);
            end
            if (roll >= 2)
            begin
                send_command(c);
                i++;
            end
        end
    endtask

    task automatic run_phase(input int unsigned k_setting, input int unsigned want,
                             input int count_word, input int unsigned items);
        logic [KMER_W-1:0] span, stride, key;
        int unsigned       i;
        plan_len = (k_setting == 0) ? 1 : ((k_setting > MAX_K) ? MAX_K : k_setting);
        table_keys.delete();
        base_plan.delete();
        if (want != 0)
        begin
            span = (plan_len >= MAX_K) ? '1 : (64'd1 << (2 * plan_len));
            if (plan_len < MAX_K && want > span)
                want = span[31:0];
            stride = span / want;
            key = {$urandom, $urandom} % stride;
            for (i = 0; i < want; i++)
            begin
                table_keys.push_back(key);
                send_load(i[IDX_W-1:0], key);
                key = key + 64'd1 + ({$urandom, $urandom} % stride);
            end
        end
        drain();
        write_registers(length_word(k_setting),
                        CFG_DATA_W'((count_word < 0) ? table_keys.size() : count_word));
        stream_reads(items);
        drain();
    endtask

    initial
    begin
        cmd_t c;
        tracker = new();
        idle_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_registers(length_word(3), '0);
        send_load(0, '0);
        send_load(1, 64'd6);
        send_load(2, 64'd27);
        send_load(3, '1);
        drain();
        write_registers(length_word(3), 13'd4);
        send_base(CHAR_LOWER_A, 1'b0);
        send_base(CHAR_C + CASE_OFFSET, 1'b0);
        send_base(CHAR_G + CASE_OFFSET, 1'b0);
        send_base(CHAR_T, 1'b0);
        send_base(8'hFF, 1'b0);
        send_base(CHAR_A, 1'b0);
        send_base(CHAR_A, 1'b0);
        send_base(CHAR_A, 1'b0);
        send_base(CHAR_LOWER_Z, 1'b0);
        send_base(CHAR_T, 1'b0);
        send_base(CHAR_T, 1'b0);
        send_base(CHAR_T, 1'b1);
        send_base(8'h00, 1'b0);
        send_count(1);
        c = '1;
        c.mode = MODE_UNUSED;
        send_command(c);
        send_load('1, '1);
        send_count('1);
        drain();

        run_phase(5, 20, -1, 40);
        run_phase(1, 8, -1, 30);
        run_phase(0, 3, -1, 25);
        idle_on = 1'b0;
        run_phase(32, 24, -1, 50);
        idle_on = 1'b1;
        run_phase(63, 12, -1, 30);
        run_phase(11, 60, -1, 40);
        run_phase(25, 0, -1, 20);
        repeat (4)
            run_phase($urandom_range(1, MAX_K), $urandom_range(1, 30), -1, 30);

        drain();
        repeat (60) @(posedge clk);
        if (tracker.expected_words.size() != 0)
            tracker.report("words never returned", tracker.expected_words.size(), '0);
        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
